>>> design/hpsl_pkg.sv
package hpsl_pkg;

    localparam int REMOTE_SLOTS       = 4;
    localparam int REPORTS_PER_REMOTE = 8;
    localparam int SIGNATURE_SLOTS    = 8;
    localparam int REPORT_BYTES       = 16;

    localparam int LINK_COUNT = REMOTE_SLOTS * REPORTS_PER_REMOTE;
    localparam int LINK_W     = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
    localparam int SIG_W      = (SIGNATURE_SLOTS > 1) ? $clog2(SIGNATURE_SLOTS) : 1;

    localparam logic [23:0] COOLDOWN_RESET = 24'(300 * 1000);
    localparam logic [31:0] DEVICE_MASK    = 32'hFF00_0000;

    typedef enum logic [1:0] {
        KIND_REPORT = 2'd0,
        KIND_DROP   = 2'd1,
        KIND_FORGET = 2'd2
    } kind_t;

    typedef struct packed {
        logic [3:0] offset;
        logic [7:0] value;
    } press_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [LINK_W-1:0] addr;
        press_t            wr_data;
        logic              clr_all;
        logic              clr_dev;
        logic [2:0]        dev;
    } link_cmd_t;

    typedef struct packed {
        logic hit_a;
        logic hit_b;
    } match_t;

    function automatic logic [31:0] make_key(
        input logic [2:0] dev,
        input logic [2:0] rep,
        input press_t     press
    );
        logic [31:0] key;
        key = {5'b0, dev, 5'b0, rep, 4'b0, press.offset, press.value};
        return key;
    endfunction

endpackage

>>> design/hpsl_match.sv
module hpsl_match (
    input  logic [31:0]     entry,
    input  logic [31:0]     key_a,
    input  logic [31:0]     mask_a,
    input  logic [31:0]     key_b,
    output hpsl_pkg::match_t hit
);

    always_comb
    begin
        hit.hit_a = (((entry ^ key_a) & mask_a) == 32'd0);
        hit.hit_b = (entry == key_b);
    end

endmodule

>>> design/hpsl_link_store.sv
module hpsl_link_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hpsl_pkg::link_cmd_t  cmd,
    output hpsl_pkg::press_t     rd_press
);

    hpsl_pkg::press_t                    link_mem [hpsl_pkg::LINK_COUNT];
    hpsl_pkg::press_t                    rd_data_reg;
    logic                                rd_valid_reg;
    logic [hpsl_pkg::LINK_COUNT-1:0]     valid_reg;
    logic [hpsl_pkg::LINK_COUNT-1:0]     valid_next;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            link_mem[cmd.addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= link_mem[cmd.addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.wr_en)
        begin
            valid_next[cmd.addr] = 1'b1;
        end
        for (int k = 0; k < hpsl_pkg::LINK_COUNT; k++)
        begin
            if (cmd.clr_all ||
                (cmd.clr_dev && (k / hpsl_pkg::REPORTS_PER_REMOTE) == int'(cmd.dev)))
            begin
                valid_next[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.rd_en)
            begin
                rd_valid_reg <= valid_reg[cmd.addr];
            end
        end
    end

    assign rd_press = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> design/hid_press_signature_learner.sv
// A report or disconnect request passes one link-store read, one table scan step per
// signature slot and one update; forget, unknown kinds and out-of-range requests skip
// the scan. A new request is taken only once the last result is registered, which waits
// while a held output has not yet been taken by m_tready.
// Reset (async, active low) clears held mask, button count, active links and press
// times and loads cooldown 300000; learned signature entries stay undefined.
module hid_press_signature_learner (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // device[2:0], report[5:3], data_low[69:6], data_high[133:70], length[138:134],
    // time_us[186:139], zero[191:187]
    input  logic [191:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // fire[0], button[3:1], learned[4], learned_key[36:5], table_full[37],
    // held_map[45:38], learned_total[49:46], zero[55:50]
    output logic [55:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [23:0]  cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [1:0]   kind_reg;
    logic [2:0]   dev_reg;
    logic [2:0]   rep_reg;
    logic [127:0] bytes_reg;
    logic [4:0]   len_reg;
    logic [47:0]  now_reg;

    hpsl_pkg::press_t new_press;
    hpsl_pkg::press_t new_press_reg;
    hpsl_pkg::press_t rd_press;

    logic [31:0]  sig_table [hpsl_pkg::SIGNATURE_SLOTS];
    logic [47:0]  last_time_reg [hpsl_pkg::SIGNATURE_SLOTS];
    logic [3:0]   count_reg;
    logic [3:0]   count_next;
    logic [7:0]   held_reg;
    logic [7:0]   held_next;
    logic [23:0]  cooldown_reg;

    logic [hpsl_pkg::SIG_W-1:0] idx_reg;
    logic                       rel_found_reg;
    logic [hpsl_pkg::SIG_W-1:0] rel_idx_reg;
    logic                       btn_found_reg;
    logic [hpsl_pkg::SIG_W-1:0] btn_idx_reg;
    logic [7:0]                 drop_mask_reg;

    logic         fire_reg;
    logic [2:0]   button_reg;
    logic         learned_reg;
    logic [31:0]  lkey_reg;
    logic         full_reg;
    logic         out_valid_reg;

    logic         fire_next;
    logic [2:0]   button_next;
    logic         learned_next;
    logic [31:0]  lkey_next;
    logic         full_next;
    logic         stamp;
    logic [hpsl_pkg::SIG_W-1:0] btn;

    logic         in_accept;
    logic         dev_ok;
    logic         in_range;
    logic         report_kind;
    logic         go;
    logic         live;
    logic [4:0]   len_eff;
    logic [hpsl_pkg::LINK_W-1:0] slot;
    logic [31:0]  old_key;
    logic [31:0]  new_key;
    logic [31:0]  key_a;
    logic [31:0]  mask_a;
    logic [48:0]  diff;
    logic [7:0]   held_cleared;
    logic [7:0]   bit_sel;

    hpsl_pkg::link_cmd_t link_cmd;
    hpsl_pkg::match_t    hit;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'b0, count_reg, held_reg, full_reg, lkey_reg, learned_reg,
                        button_reg, fire_reg};

    assign dev_ok      = ({1'b0, dev_reg} < 4'(hpsl_pkg::REMOTE_SLOTS));
    assign in_range    = dev_ok && ({1'b0, rep_reg} < 4'(hpsl_pkg::REPORTS_PER_REMOTE));
    assign report_kind = (kind_reg == hpsl_pkg::KIND_REPORT);
    assign slot      = hpsl_pkg::LINK_W'(int'(dev_reg) * hpsl_pkg::REPORTS_PER_REMOTE
                                         + int'(rep_reg));
    assign go        = !out_valid_reg || m_tready;
    assign live      = (4'(idx_reg) < count_reg);
    assign old_key   = hpsl_pkg::make_key(dev_reg, rep_reg, rd_press);
    assign new_key   = hpsl_pkg::make_key(dev_reg, rep_reg, new_press_reg);
    assign key_a     = report_kind ? old_key : {5'b0, dev_reg, 24'b0};
    assign mask_a    = report_kind ? 32'hFFFF_FFFF : hpsl_pkg::DEVICE_MASK;

    always_comb
    begin
        len_eff   = (len_reg > 5'(hpsl_pkg::REPORT_BYTES)) ? 5'(hpsl_pkg::REPORT_BYTES)
                                                           : len_reg;
        new_press = '0;
        for (int i = hpsl_pkg::REPORT_BYTES - 1; i >= 0; i--)
        begin
            if (5'(i) < len_eff && bytes_reg[8*i +: 8] != 8'd0)
            begin
                new_press.offset = 4'(i);
                new_press.value  = bytes_reg[8*i +: 8];
            end
        end
    end

    hpsl_match u_match (
        .entry  (sig_table[idx_reg]),
        .key_a  (key_a),
        .mask_a (mask_a),
        .key_b  (new_key),
        .hit    (hit)
    );

    hpsl_link_store u_link (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (link_cmd),
        .rd_press (rd_press)
    );

    always_comb
    begin
        held_next    = held_reg;
        count_next   = count_reg;
        fire_next    = 1'b0;
        button_next  = 3'd0;
        learned_next = 1'b0;
        lkey_next    = 32'd0;
        full_next    = 1'b0;
        stamp        = 1'b0;
        btn          = btn_idx_reg;
        held_cleared = held_reg;
        bit_sel      = 8'd0;
        diff         = 49'd0;

        link_cmd         = '0;
        link_cmd.addr    = slot;
        link_cmd.wr_data = new_press_reg;
        link_cmd.dev     = dev_reg;
        link_cmd.rd_en   = (state_reg == ST_LOAD);

        case (kind_reg)
            hpsl_pkg::KIND_REPORT:
            begin
                if (in_range && new_press_reg != rd_press)
                begin
                    link_cmd.wr_en = 1'b1;
                    if (rel_found_reg && rd_press.value != 8'd0)
                    begin
                        held_cleared = held_reg & ~(8'd1 << rel_idx_reg);
                    end
                    held_next = held_cleared;
                    if (new_press_reg.value != 8'd0)
                    begin
                        if (!btn_found_reg)
                        begin
                            if (count_reg < 4'(hpsl_pkg::SIGNATURE_SLOTS))
                            begin
                                btn          = count_reg[hpsl_pkg::SIG_W-1:0];
                                learned_next = 1'b1;
                                lkey_next    = new_key;
                                count_next   = count_reg + 4'd1;
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                        if (btn_found_reg || !full_next)
                        begin
                            bit_sel     = 8'd1 << btn;
                            button_next = 3'(btn);
                            diff        = {1'b0, now_reg} - {1'b0, last_time_reg[btn]};
                            if ((held_cleared & bit_sel) == 8'd0 && !diff[48] &&
                                diff[47:0] > {24'd0, cooldown_reg})
                            begin
                                fire_next = 1'b1;
                                stamp     = 1'b1;
                            end
                            held_next = held_cleared | bit_sel;
                        end
                    end
                end
            end
            hpsl_pkg::KIND_DROP:
            begin
                if (dev_ok)
                begin
                    held_next        = held_reg & ~drop_mask_reg;
                    link_cmd.clr_dev = 1'b1;
                end
            end
            hpsl_pkg::KIND_FORGET:
            begin
                held_next        = 8'd0;
                count_next       = 4'd0;
                link_cmd.clr_all = 1'b1;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase

        if (!(state_reg == ST_UPDATE && go))
        begin
            link_cmd.wr_en   = 1'b0;
            link_cmd.clr_dev = 1'b0;
            link_cmd.clr_all = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if ((report_kind && in_range) ||
                    (kind_reg == hpsl_pkg::KIND_DROP && dev_ok))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == hpsl_pkg::SIG_W'(hpsl_pkg::SIGNATURE_SLOTS - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            fire_reg      <= 1'b0;
            button_reg    <= 3'd0;
            learned_reg   <= 1'b0;
            lkey_reg      <= 32'd0;
            full_reg      <= 1'b0;
            held_reg      <= 8'd0;
            count_reg     <= 4'd0;
            cooldown_reg  <= hpsl_pkg::COOLDOWN_RESET;
            idx_reg       <= '0;
            rel_found_reg <= 1'b0;
            btn_found_reg <= 1'b0;
            for (int k = 0; k < hpsl_pkg::SIGNATURE_SLOTS; k++)
            begin
                last_time_reg[k] <= 48'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                cooldown_reg <= cfg_data;
            end
            if (state_reg == ST_UPDATE && go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    idx_reg       <= '0;
                    rel_found_reg <= 1'b0;
                    btn_found_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (live && hit.hit_a)
                    begin
                        rel_found_reg <= 1'b1;
                    end
                    if (live && hit.hit_b)
                    begin
                        btn_found_reg <= 1'b1;
                    end
                end
                ST_UPDATE:
                begin
                    if (go)
                    begin
                        fire_reg      <= fire_next;
                        button_reg    <= button_next;
                        learned_reg   <= learned_next;
                        lkey_reg      <= lkey_next;
                        full_reg      <= full_next;
                        held_reg      <= held_next;
                        count_reg     <= count_next;
                        if (stamp)
                        begin
                            last_time_reg[btn] <= now_reg;
                        end
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg  <= s_tuser;
            dev_reg   <= s_tdata[2:0];
            rep_reg   <= s_tdata[5:3];
            bytes_reg <= s_tdata[133:6];
            len_reg   <= s_tdata[138:134];
            now_reg   <= s_tdata[186:139];
        end
        if (state_reg == ST_LOAD)
        begin
            new_press_reg <= new_press;
            drop_mask_reg <= 8'd0;
        end
        if (state_reg == ST_SCAN)
        begin
            if (live && hit.hit_a)
            begin
                rel_idx_reg            <= idx_reg;
                drop_mask_reg[idx_reg] <= 1'b1;
            end
            if (live && hit.hit_b)
            begin
                btn_idx_reg <= idx_reg;
            end
        end
        if (state_reg == ST_UPDATE && go && learned_next)
        begin
            sig_table[btn] <= new_key;
        end
    end

endmodule

>>> tb/sv/tb_hid_press_signature_learner.sv
`timescale 1ns / 100ps

module tb_hid_press_signature_learner;

    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int LINKS = hpsl_pkg::REMOTE_SLOTS * hpsl_pkg::REPORTS_PER_REMOTE;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] time_us;
        logic [4:0]  length;
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [2:0]  report;
        logic [2:0]  device;
    } hid_event_t;

    typedef struct packed {
        logic [3:0]  learned_total;
        logic [7:0]  held_map;
        logic        table_full;
        logic [31:0] learned_key;
        logic        learned;
        logic [2:0]  button;
        logic        fire;
    } press_outcome_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [23:0]  cfg_data = '0;

    // press tracking state
    logic [23:0] cooldown_limit = hpsl_pkg::COOLDOWN_RESET;
    logic [31:0] learned_sigs [hpsl_pkg::SIGNATURE_SLOTS];
    int          learned_count = 0;
    logic [7:0]  held_buttons = '0;
    logic [47:0] last_fire_time [hpsl_pkg::SIGNATURE_SLOTS];
    logic [31:0] link_sig [LINKS];

    hid_event_t     queued_events [$];
    press_outcome_t awaited_outcomes [$];
    hid_event_t     offered_event;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          holdoff_req = 0;
    int          holdoff_seen = 0;
    int          holdoff_left = 0;
    int          error_count = 0;
    logic [47:0] now_us = '0;

    hid_press_signature_learner dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    initial
    begin
        for (int i = 0; i < hpsl_pkg::SIGNATURE_SLOTS; i++)
        begin
            learned_sigs[i] = '0;
            last_fire_time[i] = '0;
        end
        for (int i = 0; i < LINKS; i++)
            link_sig[i] = '0;
    end

    function automatic int find_button(logic [31:0] sig);
        for (int i = 0; i < learned_count; i++)
            if (learned_sigs[i] == sig)
                return i;
        return -1;
    endfunction

    function automatic void release_device(int dev);
        int slot;
        int b;
        for (int r = 0; r < hpsl_pkg::REPORTS_PER_REMOTE; r++)
        begin
            slot = dev * hpsl_pkg::REPORTS_PER_REMOTE + r;
            if (link_sig[slot] != 0)
            begin
                b = find_button(link_sig[slot]);
                if (b >= 0)
                    held_buttons[b] = 1'b0;
            end
            link_sig[slot] = '0;
        end
    endfunction

    function automatic press_outcome_t learn_from_event(hid_event_t ev);
        press_outcome_t res;
        int             slot;
        int             rel;
        int             btn;
        int             n;
        logic [31:0]    sig;
        logic [7:0]     b;
        logic [47:0]    last;
        res = '0;
        if (ev.kind == hpsl_pkg::KIND_DROP)
        begin
            if (ev.device < hpsl_pkg::REMOTE_SLOTS)
                release_device(ev.device);
        end
        else if (ev.kind == hpsl_pkg::KIND_FORGET)
        begin
            for (int d = 0; d < hpsl_pkg::REMOTE_SLOTS; d++)
                release_device(d);
            learned_count = 0;
            held_buttons = '0;
        end
        else if (ev.kind == hpsl_pkg::KIND_REPORT && ev.device < hpsl_pkg::REMOTE_SLOTS
                 && ev.report < hpsl_pkg::REPORTS_PER_REMOTE)
        begin
            slot = ev.device * hpsl_pkg::REPORTS_PER_REMOTE + ev.report;
            n = (ev.length > hpsl_pkg::REPORT_BYTES) ? hpsl_pkg::REPORT_BYTES : ev.length;
            sig = '0;
            for (int i = 0; i < n; i++)
            begin
                b = (i < 8) ? ev.data_low[8*i +: 8] : ev.data_high[8*(i-8) +: 8];
                if (b != 0 && sig == 0)
                    sig = {5'b0, ev.device, 5'b0, ev.report, 8'(i), b};
            end
            if (sig != link_sig[slot])
            begin
                rel = (link_sig[slot] != 0) ? find_button(link_sig[slot]) : -1;
                btn = -1;
                if (sig != 0)
                begin
                    btn = find_button(sig);
                    if (btn < 0)
                    begin
                        if (learned_count < hpsl_pkg::SIGNATURE_SLOTS)
                        begin
                            btn = learned_count;
                            learned_sigs[learned_count] = sig;
                            learned_count++;
                            res.learned = 1'b1;
                            res.learned_key = sig;
                        end
                        else
                            res.table_full = 1'b1;
                    end
                end
                link_sig[slot] = sig;
                if (rel >= 0)
                    held_buttons[rel] = 1'b0;
                if (btn >= 0)
                begin
                    res.button = 3'(btn);
                    last = last_fire_time[btn];
                    if (!held_buttons[btn] && ev.time_us >= last
                        && ev.time_us - last > cooldown_limit)
                    begin
                        last_fire_time[btn] = ev.time_us;
                        res.fire = 1'b1;
                    end
                    held_buttons[btn] = 1'b1;
                end
            end
        end
        res.held_map = held_buttons;
        res.learned_total = 4'(learned_count);
        return res;
    endfunction

    // zero every byte below off, put val at off, leave the rest random
    function automatic hid_event_t make_report(int dev, int rep, int off, int val, int len,
                                               logic [47:0] t);
        hid_event_t   ev;
        logic [127:0] bytes;
        bytes = {$urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < 16; i++)
            if (i < off)
                bytes[8*i +: 8] = 8'h00;
        if (off < 16)
            bytes[8*off +: 8] = 8'(val);
        ev.kind = hpsl_pkg::KIND_REPORT;
        ev.device = 3'(dev);
        ev.report = 3'(rep);
        ev.data_low = bytes[63:0];
        ev.data_high = bytes[127:64];
        ev.length = 5'(len);
        ev.time_us = t;
        return ev;
    endfunction

    function automatic hid_event_t random_event();
        hid_event_t ev;
        ev.kind = 2'($urandom_range(0, 3));
        ev.device = 3'($urandom_range(0, 7));
        ev.report = 3'($urandom_range(0, 7));
        ev.data_low = {$urandom, $urandom};
        ev.data_high = {$urandom, $urandom};
        ev.length = 5'($urandom_range(0, 31));
        ev.time_us = 48'({$urandom, $urandom});
        return ev;
    endfunction

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (queued_events.size() != 0 || s_tvalid || awaited_outcomes.size() != 0);
    endtask

    task automatic write_cooldown(logic [23:0] value);
        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cooldown_limit = value;
    endtask

    task automatic run_random(int count);
        int         pool_dev [10];
        int         pool_rep [10];
        int         pool_off [10];
        int         pool_val [10];
        hid_event_t ev;
        int         roll;
        int         k;
        for (int i = 0; i < 10; i++)
        begin
            pool_dev[i] = $urandom_range(0, hpsl_pkg::REMOTE_SLOTS - 1);
            pool_rep[i] = $urandom_range(0, hpsl_pkg::REPORTS_PER_REMOTE - 1);
            pool_off[i] = $urandom_range(0, 15);
            pool_val[i] = $urandom_range(1, 255);
        end
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                k = $urandom_range(0, 9);
                ev = make_report(pool_dev[k], pool_rep[k], pool_off[k], pool_val[k],
                                 $urandom_range(pool_off[k] + 1, 31), now_us);
            end
            else if (roll < 78)
                ev = make_report($urandom_range(0, hpsl_pkg::REMOTE_SLOTS - 1),
                                 $urandom_range(0, 7), 16, 0, $urandom_range(0, 31),
                                 now_us);
            else if (roll < 83)
            begin
                ev = random_event();
                ev.kind = hpsl_pkg::KIND_DROP;
            end
            else if (roll < 85)
            begin
                ev = random_event();
                ev.kind = hpsl_pkg::KIND_FORGET;
            end
            else if (roll < 88)
            begin
                ev = random_event();
                ev.kind = KIND_UNKNOWN;
            end
            else if (roll < 93)
            begin
                ev = random_event();
                ev.kind = hpsl_pkg::KIND_REPORT;
                ev.device = 3'($urandom_range(hpsl_pkg::REMOTE_SLOTS, 7));
            end
            else
                ev = make_report($urandom_range(0, hpsl_pkg::REMOTE_SLOTS - 1),
                                 $urandom_range(0, 7), $urandom_range(0, 15),
                                 $urandom_range(1, 255), $urandom_range(0, 31), now_us);
            roll = $urandom_range(0, 99);
            if (roll < 3)
                now_us = now_us - 48'($urandom_range(0, 2000000));
            else if (roll < 5)
                now_us = 48'({$urandom, $urandom});
            else
                now_us = now_us + 48'($urandom_range(0, 2 * cooldown_limit + 1000));
            ev.time_us = now_us;
            queued_events.push_back(ev);
        end
    endtask

    always @(posedge clk)
    begin
        if (holdoff_req != holdoff_seen)
        begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_seen <= holdoff_req;
        end
        else if (holdoff_left > 0)
            holdoff_left <= holdoff_left - 1;
    end

    always @(posedge clk)
    begin
        logic go;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                awaited_outcomes.push_back(learn_from_event(offered_event));
            if (!s_tvalid || s_tready)
            begin
                go = (queued_events.size() > 0) && ($urandom_range(0, 99) >= send_idle_pct);
                if (go)
                begin
                    offered_event = queued_events.pop_front();
                    s_tdata <= {5'b0, offered_event.time_us, offered_event.length,
                                offered_event.data_high, offered_event.data_low,
                                offered_event.report, offered_event.device};
                    s_tuser <= offered_event.kind;
                end
                s_tvalid <= go;
            end
        end
    end

    always @(posedge clk)
    begin
        press_outcome_t got;
        press_outcome_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[49:0];
                if (awaited_outcomes.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected result %h", $realtime, got);
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (got.fire !== want.fire || got.button !== want.button
                        || got.learned !== want.learned
                        || got.learned_key !== want.learned_key
                        || got.table_full !== want.table_full
                        || got.held_map !== want.held_map
                        || got.learned_total !== want.learned_total)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("%0t: mismatch (expected/actual)", $realtime);
                            $display("  fire %0d/%0d button %0d/%0d learned %0d/%0d key %h/%h",
                                     want.fire, got.fire, want.button, got.button,
                                     want.learned, got.learned,
                                     want.learned_key, got.learned_key);
                            $display("  full %0d/%0d mask %h/%h count %0d/%0d",
                                     want.table_full, got.table_full,
                                     want.held_map, got.held_map,
                                     want.learned_total, got.learned_total);
                        end
                    end
                end
            end
            m_tready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        hid_event_t ev;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        queued_events.push_back(make_report(0, 0, 16, 0, 16, 48'd0));
        queued_events.push_back(make_report(0, 0, 0, 8'hFF, 1, 48'd1000000));
        queued_events.push_back(make_report(0, 0, 0, 8'hFF, 1, 48'd1100000));
        queued_events.push_back(make_report(0, 0, 15, 8'h01, 16, 48'd1200000));
        queued_events.push_back(make_report(0, 0, 0, 8'hFF, 1, 48'd1250000));
        queued_events.push_back(make_report(0, 0, 16, 0, 16, 48'd1300000));
        ev = make_report(3, 7, 8, 8'hFF, 31, '1);
        ev.data_high = '1;
        queued_events.push_back(ev);
        queued_events.push_back(make_report(3, 7, 16, 0, 16, '1));
        queued_events.push_back(make_report(3, 7, 8, 8'hFF, 16, 48'd0));
        ev = make_report(1, 5, 0, 8'hFF, 0, 48'd1400000);
        ev.data_low = '1;
        ev.data_high = '1;
        queued_events.push_back(ev);
        ev = '1;
        ev.kind = hpsl_pkg::KIND_REPORT;
        queued_events.push_back(ev);
        ev = '0;
        ev.kind = hpsl_pkg::KIND_DROP;
        ev.device = 3'(hpsl_pkg::REMOTE_SLOTS);
        queued_events.push_back(ev);
        ev = '1;
        ev.kind = KIND_UNKNOWN;
        queued_events.push_back(ev);
        for (int r = 0; r < 5; r++)
            queued_events.push_back(make_report(2, r, r, 8'h10 + r, 16,
                                                48'(2000000 + r * 400000)));
        queued_events.push_back(make_report(2, 5, 3, 8'h55, 16, 48'd4500000));
        ev = random_event();
        ev.kind = hpsl_pkg::KIND_DROP;
        ev.device = 3'd2;
        queued_events.push_back(ev);
        ev.device = 3'd3;
        queued_events.push_back(ev);
        ev = '1;
        ev.kind = hpsl_pkg::KIND_FORGET;
        queued_events.push_back(ev);
        now_us = 48'd5000000;
        run_random(260);

        write_cooldown('0);
        send_idle_pct = 59;
        recv_stall_pct = 0;
        run_random(260);

        write_cooldown('1);
        send_idle_pct = 0;
        recv_stall_pct = 59;
        run_random(260);

        write_cooldown(24'($urandom));
        send_idle_pct = 26;
        recv_stall_pct = 26;
        run_random(260);
        holdoff_req++;

        write_cooldown(hpsl_pkg::COOLDOWN_RESET);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(260);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && awaited_outcomes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> hid_press_signature_learner.f
design/hpsl_pkg.sv
design/hpsl_match.sv
design/hpsl_link_store.sv
design/hid_press_signature_learner.sv
tb/sv/tb_hid_press_signature_learner.sv
